>>> hw/rtl/assert_macros.svh
// assertion macros shared by the camera orientation vectors rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define COV_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define COV_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define COV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define COV_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define COV_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define COV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/cov_pkg.sv
// shared constants, types and q30 arithmetic helpers for the orientation vector pipeline
package cov_pkg;

    // default angle and fraction widths
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;

    // stream field widths
    localparam int FIELD_W     = 16;
    localparam int IN_TDATA_W  = 2 * FIELD_W;
    localparam int OUT_TDATA_W = 6 * FIELD_W;

    // pipeline depth: sine lanes, then the product mixer
    localparam int LANE_STAGES = 9;
    localparam int MIX_STAGES  = 2;
    localparam int PIPE_STAGES = LANE_STAGES + MIX_STAGES;

    // q30 words and their full products
    typedef logic [30:0] q30_t;
    typedef logic [61:0] prod_t;

    localparam prod_t Q30_HALF = prod_t'(1) << 29;

    // odd sine polynomial coefficients in q30
    localparam q30_t COEF1 = 31'd1686629713;
    localparam q30_t COEF3 = 31'd693598668;
    localparam q30_t COEF5 = 31'd85569306;
    localparam q30_t COEF7 = 31'd5026995;
    localparam q30_t COEF9 = 31'd172272;

    // handshake status of the pipeline control
    typedef struct packed {
        logic s_ready;
        logic m_valid;
    } pipe_status_t;

    // full unsigned product of two q30 words
    function automatic prod_t mul_q30(input q30_t a, input q30_t b);
        prod_t wa;
        prod_t wb;
        wa = {31'b0, a};
        wb = {31'b0, b};
        return wa * wb;
    endfunction

    // q30 product rounded half up back to q30
    function automatic q30_t round_q30(input prod_t p);
        prod_t sum;
        sum = p + Q30_HALF;
        return sum[60:30];
    endfunction

endpackage

>>> hw/rtl/camera_orientation_vectors_unit.sv
// top level: yaw and pitch binary angles to view direction and up vector
// Takes one yaw/pitch pair per cycle unless a full pipeline waits on the
// output, and returns the unit view direction (cos p sin y, sin p,
// cos p cos y) and the up vector (-sin y sin p, cos p, -cos y sin p) in
// signed Q1.FRAC_BITS, one result per input, in order. An item passes four
// parallel sine lanes of 9 stages each (quadrant fold, squaring, five chained
// q30 multiplies of the odd polynomial, rounding, scale and clamp), then 2
// stages of the product mixer. Each pipeline stage holds one item and a stalled
// output only stops the stages behind it once they are full, so bubbles are
// squeezed out while the result waits.
`include "assert_macros.svh"

module camera_orientation_vectors_unit #(
    parameter int ANGLE_BITS = cov_pkg::ANGLE_BITS,
    parameter int FRAC_BITS  = cov_pkg::FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // yaw_angle [15:0], pitch_angle [31:16]
    input  logic [cov_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // dir_x [15:0], dir_y [31:16], dir_z [47:32], up_x [63:48], up_y [79:64], up_z [95:80]
    output logic [cov_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int FW = cov_pkg::FIELD_W;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam int ONE_INT = 1 << FRAC_BITS;

    logic [cov_pkg::PIPE_STAGES-1:0] stage_en;
    cov_pkg::pipe_status_t           status;

    logic [ANGLE_BITS-1:0] yaw;
    logic [ANGLE_BITS-1:0] pitch;
    logic [ANGLE_BITS-1:0] yaw_cos;
    logic [ANGLE_BITS-1:0] pitch_cos;

    logic                  sy_neg;
    logic                  cy_neg;
    logic                  sp_neg;
    logic                  cp_neg;
    logic [FRAC_BITS:0]    sy_mag;
    logic [FRAC_BITS:0]    cy_mag;
    logic [FRAC_BITS:0]    sp_mag;
    logic [FRAC_BITS:0]    cp_mag;

    logic [FW-1:0] dir_x;
    logic [FW-1:0] dir_y;
    logic [FW-1:0] dir_z;
    logic [FW-1:0] up_x;
    logic [FW-1:0] up_y;
    logic [FW-1:0] up_z;

    // angles wrap modulo a full turn; cosine is sine a quarter turn ahead
    assign yaw       = ANGLE_BITS'(s_tdata[FW-1:0]);
    assign pitch     = ANGLE_BITS'(s_tdata[2*FW-1:FW]);
    assign yaw_cos   = yaw + QUARTER_TURN;
    assign pitch_cos = pitch + QUARTER_TURN;

    // pipeline control
    cov_pipe_ctrl #(
        .STAGES (cov_pkg::PIPE_STAGES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .stage_en (stage_en),
        .status   (status)
    );

    assign s_tready = status.s_ready;
    assign m_tvalid = status.m_valid;

    // four sine lanes
    cov_sine #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_sin_yaw (
        .aclk     (aclk),
        .stage_en (stage_en[cov_pkg::LANE_STAGES-1:0]),
        .angle    (yaw),
        .sine_neg (sy_neg),
        .sine_mag (sy_mag)
    );

    cov_sine #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cos_yaw (
        .aclk     (aclk),
        .stage_en (stage_en[cov_pkg::LANE_STAGES-1:0]),
        .angle    (yaw_cos),
        .sine_neg (cy_neg),
        .sine_mag (cy_mag)
    );

    cov_sine #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_sin_pitch (
        .aclk     (aclk),
        .stage_en (stage_en[cov_pkg::LANE_STAGES-1:0]),
        .angle    (pitch),
        .sine_neg (sp_neg),
        .sine_mag (sp_mag)
    );

    cov_sine #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cos_pitch (
        .aclk     (aclk),
        .stage_en (stage_en[cov_pkg::LANE_STAGES-1:0]),
        .angle    (pitch_cos),
        .sine_neg (cp_neg),
        .sine_mag (cp_mag)
    );

    // products and output register
    cov_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .aclk     (aclk),
        .stage_en (stage_en[cov_pkg::PIPE_STAGES-1:cov_pkg::LANE_STAGES]),
        .sy_neg   (sy_neg),
        .sy_mag   (sy_mag),
        .cy_neg   (cy_neg),
        .cy_mag   (cy_mag),
        .sp_neg   (sp_neg),
        .sp_mag   (sp_mag),
        .cp_neg   (cp_neg),
        .cp_mag   (cp_mag),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .up_x     (up_x),
        .up_y     (up_y),
        .up_z     (up_z)
    );

    assign m_tdata = {up_z, up_y, up_x, dir_z, dir_y, dir_x};

    // input is refused only while a full pipeline waits on the output
    `COV_ASSERT_ALWAYS(a_stall_only_on_output, aclk, aresetn, s_tready || (m_tvalid && !m_tready))
    // a delivered sine component stays within plus or minus one
    `COV_ASSERT_IMPL(a_dir_y_range, aclk, aresetn, m_tvalid && (FRAC_BITS <= 14), ($signed(m_tdata[2*FW-1:FW]) <= ONE_INT) && ($signed(m_tdata[2*FW-1:FW]) >= -ONE_INT))

endmodule

>>> hw/rtl/cov_sine.sv
// nine stage fixed point sine lane: quadrant fold, q30 polynomial, scale and clamp
module cov_sine #(
    parameter int ANGLE_BITS = cov_pkg::ANGLE_BITS,
    parameter int FRAC_BITS  = cov_pkg::FRAC_BITS
) (
    input  logic                            aclk,
    input  logic [cov_pkg::LANE_STAGES-1:0] stage_en,
    input  logic [ANGLE_BITS-1:0]           angle,
    output logic                            sine_neg,
    output logic [FRAC_BITS:0]              sine_mag
);

    localparam int XSHIFT = 32 - ANGLE_BITS;
    localparam logic [ANGLE_BITS-2:0] QUARTER = {1'b1, {(ANGLE_BITS - 2){1'b0}}};
    localparam logic [32:0] ROUND_ADD = 33'(1) << (30 - FRAC_BITS);
    localparam logic [32:0] ONE_WIDE  = 33'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [1:0]               quad;
    logic [ANGLE_BITS-2:0]    r_fold;
    cov_pkg::q30_t            x_next;
    cov_pkg::q30_t            sq_next;
    logic [32:0]              scaled;
    logic [FRAC_BITS:0]       mag_next;

    cov_pkg::q30_t            x_reg [0:5];
    cov_pkg::q30_t            sq_reg [2:4];
    cov_pkg::prod_t           prod_reg [1:6];
    cov_pkg::q30_t            s_reg;
    logic [FRAC_BITS:0]       mag_reg;
    logic [cov_pkg::LANE_STAGES-1:0] neg_reg;

    // quadrant fold: odd quadrants mirror, upper half turn negates
    assign quad = angle[ANGLE_BITS-1 -: 2];

    always_comb begin
        r_fold = {1'b0, angle[ANGLE_BITS-3:0]};
        if (quad[0]) begin
            r_fold = QUARTER - {1'b0, angle[ANGLE_BITS-3:0]};
        end
        x_next = 31'(r_fold) << XSHIFT;
    end

    // x squared in q30
    assign sq_next = cov_pkg::round_q30(prod_reg[1]);

    // scale to q frac_bits with round half up, clamp at one
    always_comb begin
        scaled   = (({2'b00, s_reg} << 1) + ROUND_ADD) >> (31 - FRAC_BITS);
        mag_next = (scaled > ONE_WIDE) ? ONE : scaled[FRAC_BITS:0];
    end

    // polynomial pipeline, at most one multiply per stage
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            x_reg[0]   <= x_next;
            neg_reg[0] <= quad[1];
        end
        if (stage_en[1]) begin
            prod_reg[1] <= cov_pkg::mul_q30(x_reg[0], x_reg[0]);
            x_reg[1]    <= x_reg[0];
        end
        if (stage_en[2]) begin
            sq_reg[2]   <= sq_next;
            prod_reg[2] <= cov_pkg::mul_q30(sq_next, cov_pkg::COEF9);
            x_reg[2]    <= x_reg[1];
        end
        if (stage_en[3]) begin
            prod_reg[3] <= cov_pkg::mul_q30(sq_reg[2],
                               cov_pkg::COEF7 - cov_pkg::round_q30(prod_reg[2]));
            sq_reg[3]   <= sq_reg[2];
            x_reg[3]    <= x_reg[2];
        end
        if (stage_en[4]) begin
            prod_reg[4] <= cov_pkg::mul_q30(sq_reg[3],
                               cov_pkg::COEF5 - cov_pkg::round_q30(prod_reg[3]));
            sq_reg[4]   <= sq_reg[3];
            x_reg[4]    <= x_reg[3];
        end
        if (stage_en[5]) begin
            prod_reg[5] <= cov_pkg::mul_q30(sq_reg[4],
                               cov_pkg::COEF3 - cov_pkg::round_q30(prod_reg[4]));
            x_reg[5]    <= x_reg[4];
        end
        if (stage_en[6]) begin
            prod_reg[6] <= cov_pkg::mul_q30(x_reg[5],
                               cov_pkg::COEF1 - cov_pkg::round_q30(prod_reg[5]));
        end
        if (stage_en[7]) begin
            s_reg <= cov_pkg::round_q30(prod_reg[6]);
        end
        if (stage_en[8]) begin
            mag_reg <= mag_next;
        end
        // sign follows its item down the lane
        for (int k = 1; k < cov_pkg::LANE_STAGES; k++) begin
            if (stage_en[k]) begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign sine_neg = neg_reg[cov_pkg::LANE_STAGES-1];
    assign sine_mag = mag_reg;

endmodule

>>> hw/rtl/cov_mix.sv
// two stage mixer: trig products, rounding, signs and field packing
module cov_mix #(
    parameter int FRAC_BITS = cov_pkg::FRAC_BITS
) (
    input  logic                           aclk,
    input  logic [cov_pkg::MIX_STAGES-1:0] stage_en,
    input  logic                           sy_neg,
    input  logic [FRAC_BITS:0]             sy_mag,
    input  logic                           cy_neg,
    input  logic [FRAC_BITS:0]             cy_mag,
    input  logic                           sp_neg,
    input  logic [FRAC_BITS:0]             sp_mag,
    input  logic                           cp_neg,
    input  logic [FRAC_BITS:0]             cp_mag,
    output logic [cov_pkg::FIELD_W-1:0]    dir_x,
    output logic [cov_pkg::FIELD_W-1:0]    dir_y,
    output logic [cov_pkg::FIELD_W-1:0]    dir_z,
    output logic [cov_pkg::FIELD_W-1:0]    up_x,
    output logic [cov_pkg::FIELD_W-1:0]    up_y,
    output logic [cov_pkg::FIELD_W-1:0]    up_z
);

    localparam int FW = cov_pkg::FIELD_W;
    localparam int MW = FRAC_BITS + 2;
    localparam int PW = 2 * FRAC_BITS + 2;
    localparam int RW = PW + 1;
    localparam logic [RW-1:0] HALF = RW'(1) << (FRAC_BITS - 1);

    logic [PW-1:0]      prod_reg [4];
    logic [3:0]         pneg_reg;
    logic [FRAC_BITS:0] sp_mag_reg;
    logic [FRAC_BITS:0] cp_mag_reg;
    logic               sp_neg_reg;
    logic               cp_neg_reg;

    logic [FW-1:0]      dir_x_reg;
    logic [FW-1:0]      dir_y_reg;
    logic [FW-1:0]      dir_z_reg;
    logic [FW-1:0]      up_x_reg;
    logic [FW-1:0]      up_y_reg;
    logic [FW-1:0]      up_z_reg;

    // signed magnitude to a two's complement field
    function automatic logic [FW-1:0] to_field(input logic neg, input logic [MW-1:0] mag);
        logic signed [MW-1:0] v;
        v = neg ? -$signed(mag) : $signed(mag);
        return FW'(v);
    endfunction

    // product magnitude rounded half away from zero
    function automatic logic [MW-1:0] round_prod(input logic [PW-1:0] p);
        logic [RW-1:0] rnd;
        rnd = RW'(p) + HALF;
        return rnd[FRAC_BITS +: MW];
    endfunction

    // stage one: four magnitude products, signs alongside
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            prod_reg[0] <= PW'(cp_mag) * PW'(sy_mag);
            prod_reg[1] <= PW'(cp_mag) * PW'(cy_mag);
            prod_reg[2] <= PW'(sy_mag) * PW'(sp_mag);
            prod_reg[3] <= PW'(cy_mag) * PW'(sp_mag);
            pneg_reg[0] <= cp_neg ^ sy_neg;
            pneg_reg[1] <= cp_neg ^ cy_neg;
            // up vector x and z carry an extra negation
            pneg_reg[2] <= ~(sy_neg ^ sp_neg);
            pneg_reg[3] <= ~(cy_neg ^ sp_neg);
            sp_mag_reg  <= sp_mag;
            cp_mag_reg  <= cp_mag;
            sp_neg_reg  <= sp_neg;
            cp_neg_reg  <= cp_neg;
        end
    end

    // stage two: rounding and output register
    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            dir_x_reg <= to_field(pneg_reg[0], round_prod(prod_reg[0]));
            dir_y_reg <= to_field(sp_neg_reg, {1'b0, sp_mag_reg});
            dir_z_reg <= to_field(pneg_reg[1], round_prod(prod_reg[1]));
            up_x_reg  <= to_field(pneg_reg[2], round_prod(prod_reg[2]));
            up_y_reg  <= to_field(cp_neg_reg, {1'b0, cp_mag_reg});
            up_z_reg  <= to_field(pneg_reg[3], round_prod(prod_reg[3]));
        end
    end

    assign dir_x = dir_x_reg;
    assign dir_y = dir_y_reg;
    assign dir_z = dir_z_reg;
    assign up_x  = up_x_reg;
    assign up_y  = up_y_reg;
    assign up_z  = up_z_reg;

endmodule

>>> hw/rtl/cov_pipe_ctrl.sv
// valid bits and per stage load enables with bubble collapse
`include "assert_macros.svh"

module cov_pipe_ctrl #(
    parameter int STAGES = cov_pkg::PIPE_STAGES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  m_tready,
    output logic [STAGES-1:0]     stage_en,
    output cov_pkg::pipe_status_t status
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] shifted;

    // a stage loads when the output drains or a bubble sits at or after it
    for (genvar k = 0; k < STAGES; k++) begin : g_en
        assign stage_en[k] = m_tready | ~(&valid_reg[STAGES-1:k]);
    end

    // valid bits advance with their data
    always_comb begin
        shifted    = {valid_reg[STAGES-2:0], s_tvalid};
        valid_next = (stage_en & shifted) | (~stage_en & valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign status.s_ready = stage_en[0];
    assign status.m_valid = valid_reg[STAGES-1];

    // items in flight change only by transactions on the two sides
    `COV_ASSERT_NEXT(a_item_count, aclk, aresetn, 1'b1, $countones(valid_reg) == $countones($past(valid_reg)) + ($past(s_tvalid && stage_en[0]) ? 1 : 0) - ($past(valid_reg[STAGES-1] && m_tready) ? 1 : 0))
    // an empty output stage lets every stage load
    `COV_ASSERT_IMPL(a_empty_out_all_move, aclk, aresetn, !valid_reg[STAGES-1], &stage_en)

endmodule

>>> tb/camera_orientation_vectors_checker.sv
// checker for the camera orientation vectors unit: predicts each result and compares it
`timescale 1ns / 100ps

module camera_orientation_vectors_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // yaw_angle [15:0], pitch_angle [31:16]
    input  logic [cov_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // dir_x [15:0], dir_y [31:16], dir_z [47:32], up_x [63:48], up_y [79:64], up_z [95:80]
    input  logic [cov_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                              mismatch_count,
    output int                              vectors_pending
);

    // polynomial coefficients of the odd sine series, q30
    localparam longint unsigned SINE_C1  = 64'd1686629713;
    localparam longint unsigned SINE_C3  = 64'd693598668;
    localparam longint unsigned SINE_C5  = 64'd85569306;
    localparam longint unsigned SINE_C7  = 64'd5026995;
    localparam longint unsigned SINE_C9  = 64'd172272;
    localparam longint unsigned Q30_RND  = 64'd1 << 29;
    localparam longint unsigned UNIT_Q14 = 64'd1 << 14;

    // field order matches the packing of m_tdata, dir_x in the lowest bits
    typedef struct packed {
        logic signed [15:0] up_z;
        logic signed [15:0] up_y;
        logic signed [15:0] up_x;
        logic signed [15:0] dir_z;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_x;
    } orientation_t;

    string field_names [6] = '{"dir_x", "dir_y", "dir_z", "up_x", "up_y", "up_z"};

    orientation_t expected_vectors [$];

    // q30 product, rounded half up
    function automatic longint unsigned q30_product(input longint unsigned a,
                                                    input longint unsigned b);
        return (a * b + Q30_RND) >> 30;
    endfunction

    // first quadrant sine of a q30 fraction of a quarter turn, result in q14
    function automatic longint unsigned quadrant_sine(input longint unsigned x);
        longint unsigned x2;
        longint unsigned p;
        longint unsigned s;
        x2 = q30_product(x, x);
        p  = SINE_C9;
        p  = SINE_C7 - q30_product(x2, p);
        p  = SINE_C5 - q30_product(x2, p);
        p  = SINE_C3 - q30_product(x2, p);
        p  = SINE_C1 - q30_product(x2, p);
        s  = q30_product(x, p);
        s  = (64'd2 * s + (64'd1 << 16)) >> 17;
        if (s > UNIT_Q14) begin
            s = UNIT_Q14;
        end
        return s;
    endfunction

    // sine of a 16-bit binary angle: fold by quadrant, negate in the upper half turn
    function automatic longint binary_sine(input logic [15:0] angle);
        logic [1:0]      quad;
        longint unsigned r;
        longint          s;
        quad = angle[15:14];
        r    = longint'(angle[13:0]);
        if (quad[0]) begin
            r = 64'd16384 - r;
        end
        s = longint'(quadrant_sine(r << 16));
        return quad[1] ? -s : s;
    endfunction

    // cosine is the sine a quarter turn ahead, wrapping at a full turn
    function automatic longint binary_cosine(input logic [15:0] angle);
        logic [15:0] ahead;
        ahead = angle + 16'd16384;
        return binary_sine(ahead);
    endfunction

    // q14 product on magnitudes, rounded half away from zero
    function automatic longint q14_product(input longint a, input longint b);
        logic            negative;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        negative = (a < 0) != (b < 0);
        ma = longint'(a < 0 ? -a : a);
        mb = longint'(b < 0 ? -b : b);
        m  = (ma * mb + (64'd1 << 13)) >> 14;
        return negative ? -longint'(m) : longint'(m);
    endfunction

    // view direction and up vector for one angle pair
    function automatic orientation_t predict_orientation(input logic [15:0] yaw,
                                                         input logic [15:0] pitch);
        orientation_t v;
        longint       sy;
        longint       cy;
        longint       sp;
        longint       cp;
        sy = binary_sine(yaw);
        cy = binary_cosine(yaw);
        sp = binary_sine(pitch);
        cp = binary_cosine(pitch);
        v.dir_x = 16'(q14_product(cp, sy));
        v.dir_y = 16'(sp);
        v.dir_z = 16'(q14_product(cp, cy));
        v.up_x  = 16'(-q14_product(sy, sp));
        v.up_y  = 16'(cp);
        v.up_z  = 16'(-q14_product(cy, sp));
        return v;
    endfunction

    // result transactions are matched first, then the new input transaction is predicted
    always @(posedge aclk) begin
        orientation_t want;
        if (!aresetn) begin
            expected_vectors.delete();
            mismatch_count = 0;
            vectors_pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_vectors.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_vectors.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (want[i*16 +: 16] !== m_tdata[i*16 +: 16]) begin
                            $display("%0t: %s expected %0d actual %0d", $time, field_names[i],
                                     $signed(want[i*16 +: 16]), $signed(m_tdata[i*16 +: 16]));
                            mismatch_count++;
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_vectors.push_back(predict_orientation(s_tdata[15:0], s_tdata[31:16]));
            end
            vectors_pending <= expected_vectors.size();
        end
    end

endmodule

>>> tb/tb_camera_orientation_vectors_unit.sv
// testbench top for the camera orientation vectors unit: stimulus, back pressure and verdict
`timescale 1ns / 100ps

module tb_camera_orientation_vectors_unit;

    localparam int RANDOM_ITEMS = 1900;

    // receiver behavior for one stretch of cycles
    typedef enum int {
        RX_ALWAYS_READY,
        RX_COIN_FLIP,
        RX_MOSTLY_READY,
        RX_STALLED
    } rx_mode_e;

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cov_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cov_pkg::OUT_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int vectors_pending;
    int burst_left = 1;

    logic [15:0] directed_yaw [24] = '{
        16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
        16'h0001, 16'h3FFF, 16'h7FFF, 16'hBFFF, 16'hFFFF, 16'h0000, 16'h2000, 16'h6000,
        16'h4000, 16'hC000, 16'h8000, 16'hAAAA, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA
    };
    logic [15:0] directed_pitch [24] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
        16'h0001, 16'h4001, 16'h8001, 16'hC001, 16'h0000, 16'hFFFF, 16'h2000, 16'hE000,
        16'h4000, 16'hC000, 16'h8000, 16'h5555, 16'h8000, 16'hFFFF, 16'hAAAA, 16'h5555
    };

    camera_orientation_vectors_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    camera_orientation_vectors_checker vector_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .vectors_pending (vectors_pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // random angle, often close to a quadrant boundary
    function automatic logic [15:0] random_angle();
        logic [15:0] base;
        if ($urandom_range(0, 9) < 6) begin
            return 16'($urandom());
        end
        base = 16'($urandom_range(0, 3)) << 14;
        return base + 16'($urandom_range(0, 8)) - 16'd4;
    endfunction

    // one input transaction, then burst pacing
    task automatic send_angles(input logic [15:0] yaw, input logic [15:0] pitch);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {pitch, yaw};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // receiver back pressure in stretches of random behavior
    initial begin
        rx_mode_e mode;
        int       span;
        forever begin
            mode = rx_mode_e'($urandom_range(0, 3));
            span = $urandom_range(1, 40);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    RX_ALWAYS_READY: begin
                        m_tready <= 1'b1;
                    end
                    RX_COIN_FLIP: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                    RX_MOSTLY_READY: begin
                        m_tready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_tready <= 1'b0;
                    end
                endcase
            end
        end
    end

    // reset, stimulus and verdict
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // axes, quadrant edges and wrap points
        for (int i = 0; i < 24; i++) begin
            send_angles(directed_yaw[i], directed_pitch[i]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_angles(random_angle(), random_angle());
        end
        s_tvalid <= 1'b0;

        // drain the pipeline
        @(posedge aclk);
        while (vectors_pending != 0) begin
            @(posedge aclk);
        end
        repeat (2 * cov_pkg::PIPE_STAGES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
